[sv/mqtt_sub_pkg.sv]
// Package for the SUBSCRIBE packet parser: phase codes, result kinds,
// error codes and the state and result structs. No dependencies.
`timescale 1ns / 1ps

package mqtt_sub_pkg;

    // Parser phases
    localparam logic [2:0] PH_FIXED   = 3'd0;
    localparam logic [2:0] PH_LENGTH  = 3'd1;
    localparam logic [2:0] PH_ID_HI   = 3'd2;
    localparam logic [2:0] PH_ID_LO   = 3'd3;
    localparam logic [2:0] PH_TLEN_HI = 3'd4;
    localparam logic [2:0] PH_TLEN_LO = 3'd5;
    localparam logic [2:0] PH_TOPIC   = 3'd6;
    localparam logic [2:0] PH_QOS     = 3'd7;

    // Result kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_TOPIC  = 2'd1;
    localparam logic [1:0] KIND_QOS    = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    // Error codes
    localparam logic ERR_TRUNCATED = 1'b0;
    localparam logic ERR_LENGTH    = 1'b1;

    // Length field limits
    localparam logic [2:0] MAX_LEN_BYTES = 3'd4;

    typedef struct packed {
        logic [2:0]  phase;
        logic [7:0]  header_byte;
        logic [27:0] length_acc;
        logic [2:0]  length_cnt;
        logic [15:0] id;
        logic [15:0] filter_length;
        logic [15:0] filter_count;
    } parse_state_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  data_value;
        logic [7:0]  fixed_header;
        logic [27:0] remaining_length;
        logic [15:0] packet_id;
        logic [15:0] topic_length;
        logic [15:0] topic_byte_index;
        logic        topic_last;
        logic        packet_end;
        logic        error_code;
    } result_t;

endpackage

[sv/mqtt_sub_byte_if.sv]
// Byte channel into the parser: valid/ready handshake with one packet byte
// and its last mark. No dependencies.
`timescale 1ns / 1ps

interface mqtt_sub_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

[sv/mqtt_sub_result_if.sv]
// Result channel out of the parser: valid/ready handshake with the decoded
// header, topic and QoS fields. No dependencies.
`timescale 1ns / 1ps

interface mqtt_sub_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  data_value;
    logic [7:0]  fixed_header;
    logic [27:0] remaining_length;
    logic [15:0] packet_id;
    logic [15:0] topic_length;
    logic [15:0] topic_byte_index;
    logic        topic_last;
    logic        packet_end;
    logic        error_code;

    modport source (
        output valid, output result_kind, output data_value, output fixed_header,
        output remaining_length, output packet_id, output topic_length,
        output topic_byte_index, output topic_last, output packet_end,
        output error_code, input ready
    );
    modport sink (
        input valid, input result_kind, input data_value, input fixed_header,
        input remaining_length, input packet_id, input topic_length,
        input topic_byte_index, input topic_last, input packet_end,
        input error_code, output ready
    );
endinterface

[sv/mqtt_sub_decode.sv]
// Per-byte decode step: next parser state and the optional result word.
// Depends on mqtt_sub_pkg.
`timescale 1ns / 1ps

module mqtt_sub_decode
    import mqtt_sub_pkg::*;
(
    input  parse_state_t state,
    input  logic [7:0]   byte_value,
    input  logic         last_byte,
    output parse_state_t state_next,
    output logic         res_valid,
    output result_t      res
);

    logic        err;
    logic        err_code;
    logic [27:0] len_bits;
    logic        filter_ends;

    // Place the 7 length bits at their group position
    always_comb
    begin
        case (state.length_cnt[1:0])
            2'd0:    len_bits = {21'd0, byte_value[6:0]};
            2'd1:    len_bits = {14'd0, byte_value[6:0], 7'd0};
            2'd2:    len_bits = {7'd0, byte_value[6:0], 14'd0};
            default: len_bits = {byte_value[6:0], 21'd0};
        endcase
    end

    assign filter_ends = ({1'b0, state.filter_count} + 17'd1) >= {1'b0, state.filter_length};

    // Advance the phase and build the result
    always_comb
    begin
        state_next = state;
        res        = '0;
        res_valid  = 1'b0;
        err        = 1'b0;
        err_code   = ERR_TRUNCATED;

        case (state.phase)
            PH_FIXED:
            begin
                state_next.header_byte = byte_value;
                state_next.length_acc  = '0;
                state_next.length_cnt  = '0;
                if (last_byte)
                    err = 1'b1;
                else
                    state_next.phase = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                state_next.length_acc = state.length_acc | len_bits;
                state_next.length_cnt = state.length_cnt + 3'd1;
                if (byte_value[7])
                begin
                    if (state_next.length_cnt >= MAX_LEN_BYTES)
                    begin
                        err      = 1'b1;
                        err_code = ERR_LENGTH;
                    end
                    else if (last_byte)
                        err = 1'b1;
                end
                else if (last_byte)
                    err = 1'b1;
                else
                    state_next.phase = PH_ID_HI;
            end
            PH_ID_HI:
            begin
                state_next.id = {byte_value, 8'd0};
                if (last_byte)
                    err = 1'b1;
                else
                    state_next.phase = PH_ID_LO;
            end
            PH_ID_LO:
            begin
                state_next.id          = {state.id[15:8], byte_value};
                res_valid              = 1'b1;
                res.result_kind        = KIND_HEADER;
                res.fixed_header       = state.header_byte;
                res.remaining_length   = state.length_acc;
                res.packet_id          = state_next.id;
                res.packet_end         = last_byte;
                state_next.phase       = last_byte ? PH_FIXED : PH_TLEN_HI;
            end
            PH_TLEN_HI:
            begin
                state_next.filter_length = {byte_value, 8'd0};
                if (last_byte)
                    err = 1'b1;
                else
                    state_next.phase = PH_TLEN_LO;
            end
            PH_TLEN_LO:
            begin
                state_next.filter_length = {state.filter_length[15:8], byte_value};
                state_next.filter_count  = '0;
                if (last_byte)
                    err = 1'b1;
                else if (state_next.filter_length == 16'd0)
                    state_next.phase = PH_QOS;
                else
                    state_next.phase = PH_TOPIC;
            end
            PH_TOPIC:
            begin
                if (last_byte)
                    err = 1'b1;
                else
                begin
                    res_valid               = 1'b1;
                    res.result_kind         = KIND_TOPIC;
                    res.data_value          = byte_value;
                    res.fixed_header        = state.header_byte;
                    res.remaining_length    = state.length_acc;
                    res.packet_id           = state.id;
                    res.topic_length        = state.filter_length;
                    res.topic_byte_index    = state.filter_count;
                    res.topic_last          = filter_ends;
                    state_next.filter_count = state.filter_count + 16'd1;
                    if (filter_ends)
                        state_next.phase = PH_QOS;
                end
            end
            default:
            begin
                // QoS byte closes one filter
                res_valid            = 1'b1;
                res.result_kind      = KIND_QOS;
                res.data_value       = byte_value;
                res.fixed_header     = state.header_byte;
                res.remaining_length = state.length_acc;
                res.packet_id        = state.id;
                res.packet_end       = last_byte;
                state_next.phase     = last_byte ? PH_FIXED : PH_TLEN_HI;
            end
        endcase

        // Error replaces any other result and restarts at the header
        if (err)
        begin
            res              = '0;
            res_valid        = 1'b1;
            res.result_kind  = KIND_ERROR;
            res.error_code   = err_code;
            state_next.phase = PH_FIXED;
        end
    end

endmodule

[sv/mqtt_subscribe_packet_parser.sv]
// MQTT SUBSCRIBE packet parser, one byte per cycle while the skid register is empty.
// A result word is registered in the output register, or in the skid when that word waits.
// Throughput: one byte per cycle while the skid is empty; the phase update is one decode step.
// A two-word output buffer (output register plus skid) keeps bytes flowing while a result waits.
// Reset (rst_n low, asynchronous): header phase, all state cleared, output buffer empty.
// Depends on mqtt_sub_pkg, mqtt_sub_byte_if, mqtt_sub_result_if, mqtt_sub_decode.
`timescale 1ns / 1ps

module mqtt_subscribe_packet_parser
    import mqtt_sub_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    mqtt_sub_byte_if.sink     packet,
    mqtt_sub_result_if.source result
);

    parse_state_t state_reg;
    parse_state_t state_next;
    logic         dec_valid;
    result_t      dec_res;

    logic         out_valid_reg;
    result_t      out_reg;
    logic         skid_valid_reg;
    result_t      skid_reg;

    logic         accept;
    logic         push;
    logic         pop;

    mqtt_sub_decode u_decode (
        .state      (state_reg),
        .byte_value (packet.byte_value),
        .last_byte  (packet.last_byte),
        .state_next (state_next),
        .res_valid  (dec_valid),
        .res        (dec_res)
    );

    assign packet.ready = !skid_valid_reg;
    assign accept       = packet.valid && packet.ready;
    assign push         = accept && dec_valid;
    assign pop          = out_valid_reg && result.ready;

    // Hold parser state; advance on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (accept)
            state_reg <= state_next;
    end

    // Output buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    // Output buffer payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_reg <= skid_reg;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_reg <= dec_res;
            else
                out_reg <= dec_res;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.result_kind      = out_reg.result_kind;
    assign result.data_value       = out_reg.data_value;
    assign result.fixed_header     = out_reg.fixed_header;
    assign result.remaining_length = out_reg.remaining_length;
    assign result.packet_id        = out_reg.packet_id;
    assign result.topic_length     = out_reg.topic_length;
    assign result.topic_byte_index = out_reg.topic_byte_index;
    assign result.topic_last       = out_reg.topic_last;
    assign result.packet_end       = out_reg.packet_end;
    assign result.error_code       = out_reg.error_code;

    // Skid holds a word only behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word without output word");

    // An error always restarts at the fixed header
    a_error_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && dec_valid && dec_res.result_kind == KIND_ERROR) |=>
        state_reg.phase == PH_FIXED)
        else $error("parser not back at header after error");

    // Topic byte position stays inside the filter
    a_topic_index: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_TOPIC |-> state_reg.filter_count < state_reg.filter_length)
        else $error("topic index past filter length");

    // Length field never counts beyond four bytes
    a_length_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.length_cnt <= MAX_LEN_BYTES)
        else $error("length byte count overflow");

endmodule

[dv/mqtt_subscribe_packet_parser_tb.sv]
// Testbench for the SUBSCRIBE packet parser: directed table, then random
// packets, each result word checked against the table or a byte-level parse model.
// Depends on mqtt_sub_pkg, mqtt_sub_byte_if, mqtt_sub_result_if and the parser.
`timescale 1ns / 1ps

module mqtt_subscribe_packet_parser_tb
    import mqtt_sub_pkg::*;
();

    localparam int TOTAL_BYTES  = 1325;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int STEADY_FROM  = 400;
    localparam int STEADY_TO    = 700;
    localparam int HOLD_START   = 900;
    localparam int HOLD_CYCLES  = 200;

    typedef struct {
        logic [7:0] value;
        logic       last;
        bit         typed;
        result_t    want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    mqtt_sub_byte_if   byte_ch();
    mqtt_sub_result_if result_ch();

    mqtt_subscribe_packet_parser dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .packet (byte_ch),
        .result (result_ch)
    );

    parse_state_t parser_state;
    result_t      results_due[$];
    stim_row_t    directed_rows[25];
    int           cycle_count = 0;
    int           bytes_sent  = 0;
    int           bad_results = 0;

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Count cycles and stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Window in which neither side idles
    function automatic bit steady_window();
        return cycle_count >= STEADY_FROM && cycle_count < STEADY_TO;
    endfunction

    function automatic result_t header_word(input logic [7:0] fh, input logic [27:0] rl,
                                            input logic [15:0] id, input logic pend);
        result_t w;
        w = '0;
        w.result_kind      = KIND_HEADER;
        w.fixed_header     = fh;
        w.remaining_length = rl;
        w.packet_id        = id;
        w.packet_end       = pend;
        return w;
    endfunction

    function automatic result_t error_word(input logic code);
        result_t w;
        w = '0;
        w.result_kind = KIND_ERROR;
        w.error_code  = code;
        return w;
    endfunction

    // Advance the parse state by one byte; return 1 when the byte yields a word
    function automatic bit parse_byte(input logic [7:0] value, input logic last,
                                      output result_t res);
        bit   emit;
        bit   fail;
        logic code;
        logic ends;
        emit = 1'b0;
        fail = 1'b0;
        code = ERR_TRUNCATED;
        ends = 1'b0;
        res  = '0;
        case (parser_state.phase)
            PH_FIXED:
            begin
                parser_state.header_byte = value;
                parser_state.length_acc  = '0;
                parser_state.length_cnt  = '0;
                fail = last;
                if (!last) parser_state.phase = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                parser_state.length_acc = parser_state.length_acc
                    | 28'(28'(value[6:0]) << (7 * parser_state.length_cnt[1:0]));
                parser_state.length_cnt = parser_state.length_cnt + 3'd1;
                // over-long length takes priority over a truncated packet
                if (value[7] && parser_state.length_cnt >= MAX_LEN_BYTES)
                begin
                    fail = 1'b1;
                    code = ERR_LENGTH;
                end
                else if (last)
                    fail = 1'b1;
                else if (!value[7])
                    parser_state.phase = PH_ID_HI;
            end
            PH_ID_HI:
            begin
                parser_state.id = {value, 8'h00};
                fail = last;
                if (!last) parser_state.phase = PH_ID_LO;
            end
            PH_ID_LO:
            begin
                parser_state.id  = parser_state.id | {8'h00, value};
                emit             = 1'b1;
                res.result_kind  = KIND_HEADER;
                res.packet_end   = last;
                parser_state.phase = last ? PH_FIXED : PH_TLEN_HI;
            end
            PH_TLEN_HI:
            begin
                parser_state.filter_length = {value, 8'h00};
                fail = last;
                if (!last) parser_state.phase = PH_TLEN_LO;
            end
            PH_TLEN_LO:
            begin
                parser_state.filter_length = parser_state.filter_length | {8'h00, value};
                parser_state.filter_count  = '0;
                fail = last;
                // an empty filter goes straight to its QoS byte
                if (!last)
                    parser_state.phase = (parser_state.filter_length == 16'd0) ? PH_QOS
                                                                               : PH_TOPIC;
            end
            PH_TOPIC:
            begin
                if (last)
                    fail = 1'b1;
                else
                begin
                    ends = ({1'b0, parser_state.filter_count} + 17'd1)
                           >= {1'b0, parser_state.filter_length};
                    emit                 = 1'b1;
                    res.result_kind      = KIND_TOPIC;
                    res.data_value       = value;
                    res.topic_length     = parser_state.filter_length;
                    res.topic_byte_index = parser_state.filter_count;
                    res.topic_last       = ends;
                    parser_state.filter_count = parser_state.filter_count + 16'd1;
                    if (ends) parser_state.phase = PH_QOS;
                end
            end
            default:
            begin
                // QoS byte closes one filter
                emit            = 1'b1;
                res.result_kind = KIND_QOS;
                res.data_value  = value;
                res.packet_end  = last;
                parser_state.phase = last ? PH_FIXED : PH_TLEN_HI;
            end
        endcase
        if (fail)
        begin
            res = error_word(code);
            parser_state.phase = PH_FIXED;
            emit = 1'b1;
        end
        else if (emit)
        begin
            res.fixed_header     = parser_state.header_byte;
            res.remaining_length = parser_state.length_acc;
            res.packet_id        = parser_state.id;
        end
        return emit;
    endfunction

    // Offer one byte with random idling, wait for the handshake, then queue its word
    task automatic send_byte(input logic [7:0] value, input logic last,
                             input bit typed, input result_t want);
        result_t parsed;
        bit      produced;
        while (!steady_window() && $urandom_range(99) < 19)
        begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.byte_value <= value;
        byte_ch.last_byte  <= last;
        @(posedge clk);
        while (!byte_ch.ready) @(posedge clk);
        produced = parse_byte(value, last, parsed);
        if (typed)
            results_due.push_back(want);
        else if (produced)
            results_due.push_back(parsed);
        bytes_sent++;
    endtask

    // Build and send one packet: mostly well formed, some cut short,
    // some with an over-long length, some plain noise
    task automatic send_random_packet();
        logic [7:0] bytes[$];
        int         pick;
        int         size_pick;
        int         n_len;
        int         n_filters;
        int         flen;
        int         stop;
        int         i;
        int         f;
        logic       mark_last;
        pick = $urandom_range(99);
        if (pick < 6)
        begin
            stop = $urandom_range(11);
            for (i = 0; i <= stop; i++)
                send_byte(8'($urandom_range(255)), i == stop || $urandom_range(5) == 0,
                          1'b0, '0);
            return;
        end
        bytes.push_back((pick < 50) ? 8'h82 : 8'($urandom_range(255)));
        if (pick < 12)
        begin
            repeat (4) bytes.push_back(8'h80 | 8'($urandom_range(127)));
            stop      = bytes.size() - 1;
            mark_last = 1'($urandom_range(1));
        end
        else
        begin
            n_len = $urandom_range(1, 4);
            for (i = 0; i < n_len; i++)
                bytes.push_back({i < n_len - 1, 7'($urandom_range(127))});
            bytes.push_back(8'($urandom_range(255)));
            bytes.push_back(8'($urandom_range(255)));
            n_filters = $urandom_range(0, 3);
            for (f = 0; f < n_filters; f++)
            begin
                size_pick = $urandom_range(99);
                if (size_pick < 1)
                    flen = $urandom_range(256, 300);
                else if (size_pick < 10)
                    flen = $urandom_range(7, 40);
                else
                    flen = $urandom_range(0, 6);
                bytes.push_back(8'(flen >> 8));
                bytes.push_back(8'(flen));
                repeat (flen) bytes.push_back(8'($urandom_range(255)));
                bytes.push_back(($urandom_range(7) == 0) ? 8'($urandom_range(255))
                                                         : 8'($urandom_range(2)));
            end
            // cut some packets short at a random byte
            stop      = (pick < 30) ? $urandom_range(bytes.size() - 1) : bytes.size() - 1;
            mark_last = 1'b1;
        end
        for (i = 0; i <= stop; i++)
            send_byte(bytes[i], (i == stop) && mark_last, 1'b0, '0);
    endtask

    // Byte source: reset, directed table, random packets, drain
    initial
    begin : byte_source
        int row;
        byte_ch.valid      <= 1'b0;
        byte_ch.byte_value <= 8'h00;
        byte_ch.last_byte  <= 1'b0;
        rst_n              <= 1'b0;
        parser_state       = '0;
        parser_state.phase = PH_FIXED;
        directed_rows = '{
            '{8'h00, 1'b1, 1'b1, error_word(ERR_TRUNCATED)},
            '{8'h82, 1'b0, 1'b0, '0},
            '{8'h02, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h01, 1'b1, 1'b1, header_word(8'h82, 28'd2, 16'h0001, 1'b1)},
            '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0},
            '{8'h7F, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b1, header_word(8'hFF, 28'hFFFFFFF, 16'hFFFF, 1'b0)},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h02, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h02, 1'b0, 1'b0, '0},
            '{8'h61, 1'b0, 1'b0, '0},
            '{8'h80, 1'b0, 1'b0, '0},
            '{8'h01, 1'b1, 1'b0, '0},
            '{8'h82, 1'b0, 1'b0, '0},
            '{8'h80, 1'b0, 1'b0, '0},
            '{8'h80, 1'b0, 1'b0, '0},
            '{8'h80, 1'b0, 1'b0, '0},
            '{8'h80, 1'b0, 1'b1, error_word(ERR_LENGTH)}
        };
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < 25; row++)
            send_byte(directed_rows[row].value, directed_rows[row].last,
                      directed_rows[row].typed, directed_rows[row].want);
        while (bytes_sent < TOTAL_BYTES)
            send_random_packet();
        byte_ch.valid <= 1'b0;

        // Wait for every queued word, then let the pipeline settle
        while (results_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (bad_results == 0 && results_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Result sink: check each accepted word, stall at random, hold off once
    initial
    begin : result_sink
        int      hold_left;
        result_t got;
        result_t want;
        hold_left = 0;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
            begin
                got.result_kind      = result_ch.result_kind;
                got.data_value       = result_ch.data_value;
                got.fixed_header     = result_ch.fixed_header;
                got.remaining_length = result_ch.remaining_length;
                got.packet_id        = result_ch.packet_id;
                got.topic_length     = result_ch.topic_length;
                got.topic_byte_index = result_ch.topic_byte_index;
                got.topic_last       = result_ch.topic_last;
                got.packet_end       = result_ch.packet_end;
                got.error_code       = result_ch.error_code;
                if (results_due.size() == 0)
                begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("unexpected word at cycle %0d: kind %0d data %h",
                                 cycle_count, got.result_kind, got.data_value);
                end
                else
                begin
                    want = results_due.pop_front();
                    if (got !== want)
                    begin
                        bad_results++;
                        if (bad_results <= 10)
                        begin
                            $display("word mismatch at cycle %0d (expected/actual):",
                                     cycle_count);
                            $display("  kind %0d/%0d data %h/%h header %h/%h length %0d/%0d",
                                     want.result_kind, got.result_kind,
                                     want.data_value, got.data_value,
                                     want.fixed_header, got.fixed_header,
                                     want.remaining_length, got.remaining_length);
                            $display("  id %h/%h tlen %0d/%0d index %0d/%0d tlast %b/%b",
                                     want.packet_id, got.packet_id,
                                     want.topic_length, got.topic_length,
                                     want.topic_byte_index, got.topic_byte_index,
                                     want.topic_last, got.topic_last);
                            $display("  end %b/%b error %b/%b",
                                     want.packet_end, got.packet_end,
                                     want.error_code, got.error_code);
                        end
                    end
                end
            end
            // Hold off once for a long stretch so the parser backs up
            if (cycle_count == HOLD_START)
                hold_left = HOLD_CYCLES;
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (steady_window())
                result_ch.ready <= 1'b1;
            else
                result_ch.ready <= ($urandom_range(99) >= 19);
        end
    end

endmodule
